@@ hdl/sth_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sth_pkg: shared widths and types for the sphere/triangle height test
// Fixed-point formats, intermediate widths and the sideband record carried
// alongside the divider pipeline.
// ---------------------------------------------------------------------------
package sth_pkg;

    localparam int CW   = 32;           // coordinate width
    localparam int FW   = 16;           // fraction bits
    localparam int RW   = CW - 1;       // radius width
    localparam int DW   = CW + 1;       // coordinate difference
    localparam int PW   = 2 * DW;       // edge product
    localparam int NW   = PW + 1;       // normal component
    localparam int LW   = NW / 2;       // low slice of a normal component
    localparam int HW   = NW - LW;      // high slice (signed)
    localparam int LPW  = LW + 1 + DW;  // low partial product
    localparam int HPW  = HW + DW;      // high partial product
    localparam int TW   = NW + DW;      // one numerator term
    localparam int NUMW = TW + 2;       // numerator
    localparam int MW   = NUMW - 1;     // numerator magnitude / quotient bits
    localparam int BW   = CW + 2;       // band and box bounds

    localparam logic [RW-1:0] RAD_RESET = RW'(1) << (FW - 1);

    typedef struct packed {
        logic signed [CW-1:0] cy;
        logic [RW-1:0]        rad;
        logic                 reject;
        logic                 degen;
        logic                 neg;
    } sth_side_t;

endpackage

@@ hdl/sth_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sth_div: pipelined restoring divider
// One quotient bit per stage, unsigned magnitudes, sideband rides along.
// ---------------------------------------------------------------------------
module sth_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [sth_pkg::MW-1:0]    in_mag,
    input  logic [sth_pkg::NW-1:0]    in_div,
    input  sth_pkg::sth_side_t        in_side,
    output logic                      out_valid,
    output logic [sth_pkg::MW-1:0]    out_quo,
    output sth_pkg::sth_side_t        out_side
);

    logic                     v_reg    [sth_pkg::MW];
    logic [sth_pkg::MW-1:0]   a_reg    [sth_pkg::MW];  // dividend out, quotient in
    logic [sth_pkg::NW-1:0]   rem_reg  [sth_pkg::MW];
    logic [sth_pkg::NW-1:0]   b_reg    [sth_pkg::MW];
    sth_pkg::sth_side_t       side_reg [sth_pkg::MW];

    for (genvar k = 0; k < sth_pkg::MW; k++) begin : g_stage
        logic                   v_prev;
        logic [sth_pkg::MW-1:0] a_prev;
        logic [sth_pkg::NW-1:0] rem_prev;
        logic [sth_pkg::NW-1:0] b_prev;
        sth_pkg::sth_side_t     side_prev;
        logic [sth_pkg::NW:0]   rem_s;
        logic                   ge;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign a_prev    = in_mag;
            assign rem_prev  = '0;
            assign b_prev    = in_div;
            assign side_prev = in_side;
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign a_prev    = a_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign b_prev    = b_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign rem_s = {rem_prev, a_prev[sth_pkg::MW-1]};
        assign ge    = rem_s >= {1'b0, b_prev};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? sth_pkg::NW'(rem_s - {1'b0, b_prev})
                                  : rem_s[sth_pkg::NW-1:0];
                a_reg[k]    <= {a_prev[sth_pkg::MW-2:0], ge};
                b_reg[k]    <= b_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[sth_pkg::MW-1];
    assign out_quo   = a_reg[sth_pkg::MW-1];
    assign out_side  = side_reg[sth_pkg::MW-1];

endmodule

@@ hdl/sphere_triangle_height_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphere_triangle_height_test: sphere against triangle plane height test
// Box reject on x/z widened by the radius, then the plane height under the
// sphere center from the unnormalized normal, exact and truncated.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid/s_ready, s_center_*, s_vert_*    | in
//  result  | m_valid/m_ready, m_hit, m_plane_height,  | out
//          | m_degenerate                             |
//  config  | cfg_valid/cfg_ready, cfg_sphere_radius   | in
//
//  One transaction per clock sustained unless the result side stalls; 7 front
//  stages, 101 quotient-bit stages of the divider, 2 back stages. The divider's one
//  bit per stage sets the depth.
//  Reset (aresetn low, synchronous) clears all valid bits and loads the
//  radius with 0.5. Stalls freeze the whole pipeline; s_ready follows
//  m_ready whenever a result is pending.
// ---------------------------------------------------------------------------
module sphere_triangle_height_test (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sth_pkg::RW-1:0]            cfg_sphere_radius,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sth_pkg::CW-1:0]     s_center_x,
    input  logic signed [sth_pkg::CW-1:0]     s_center_y,
    input  logic signed [sth_pkg::CW-1:0]     s_center_z,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_a_x,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_a_y,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_a_z,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_b_x,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_b_y,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_b_z,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_c_x,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_c_y,
    input  logic signed [sth_pkg::CW-1:0]     s_vert_c_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [sth_pkg::CW-1:0]     m_plane_height,
    output logic                              m_degenerate
);

    function automatic logic signed [sth_pkg::CW-1:0] min3(
        input logic signed [sth_pkg::CW-1:0] a,
        input logic signed [sth_pkg::CW-1:0] b,
        input logic signed [sth_pkg::CW-1:0] c
    );
        logic signed [sth_pkg::CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [sth_pkg::CW-1:0] max3(
        input logic signed [sth_pkg::CW-1:0] a,
        input logic signed [sth_pkg::CW-1:0] b,
        input logic signed [sth_pkg::CW-1:0] c
    );
        logic signed [sth_pkg::CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic en;
    logic [sth_pkg::RW-1:0] radius_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= sth_pkg::RAD_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_sphere_radius;
        end
    end

    // ---- stage 1: edges, center offsets, x/z extents
    logic v1_reg;
    logic signed [sth_pkg::DW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [sth_pkg::DW-1:0] dcx1_reg, dcz1_reg;
    logic signed [sth_pkg::CW-1:0] ay1_reg, cy1_reg, cx1_reg, cz1_reg;
    logic signed [sth_pkg::CW-1:0] minx_reg, maxx_reg, minz_reg, maxz_reg;
    logic [sth_pkg::RW-1:0]        rad1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e1x_reg  <= sth_pkg::DW'(s_vert_b_x) - sth_pkg::DW'(s_vert_a_x);
            e1y_reg  <= sth_pkg::DW'(s_vert_b_y) - sth_pkg::DW'(s_vert_a_y);
            e1z_reg  <= sth_pkg::DW'(s_vert_b_z) - sth_pkg::DW'(s_vert_a_z);
            e2x_reg  <= sth_pkg::DW'(s_vert_c_x) - sth_pkg::DW'(s_vert_a_x);
            e2y_reg  <= sth_pkg::DW'(s_vert_c_y) - sth_pkg::DW'(s_vert_a_y);
            e2z_reg  <= sth_pkg::DW'(s_vert_c_z) - sth_pkg::DW'(s_vert_a_z);
            dcx1_reg <= sth_pkg::DW'(s_center_x) - sth_pkg::DW'(s_vert_a_x);
            dcz1_reg <= sth_pkg::DW'(s_center_z) - sth_pkg::DW'(s_vert_a_z);
            ay1_reg  <= s_vert_a_y;
            cy1_reg  <= s_center_y;
            cx1_reg  <= s_center_x;
            cz1_reg  <= s_center_z;
            minx_reg <= min3(s_vert_a_x, s_vert_b_x, s_vert_c_x);
            maxx_reg <= max3(s_vert_a_x, s_vert_b_x, s_vert_c_x);
            minz_reg <= min3(s_vert_a_z, s_vert_b_z, s_vert_c_z);
            maxz_reg <= max3(s_vert_a_z, s_vert_b_z, s_vert_c_z);
            rad1_reg <= radius_reg;
        end
    end

    // ---- stage 2: edge products, box reject (edges count as inside)
    logic v2_reg;
    logic signed [sth_pkg::PW-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [sth_pkg::DW-1:0] dcx2_reg, dcz2_reg;
    logic signed [sth_pkg::CW-1:0] ay2_reg;
    sth_pkg::sth_side_t            side2_reg;
    logic signed [sth_pkg::BW-1:0] rad_b, cx_b, cz_b;
    logic                          reject;

    assign rad_b  = $signed({3'b000, rad1_reg});
    assign cx_b   = sth_pkg::BW'(cx1_reg);
    assign cz_b   = sth_pkg::BW'(cz1_reg);
    assign reject = (cx_b + rad_b < sth_pkg::BW'(minx_reg))
                 || (cx_b > sth_pkg::BW'(maxx_reg) + rad_b)
                 || (cz_b + rad_b < sth_pkg::BW'(minz_reg))
                 || (cz_b > sth_pkg::BW'(maxz_reg) + rad_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_yz_reg         <= e1y_reg * e2z_reg;
            p_zy_reg         <= e1z_reg * e2y_reg;
            p_zx_reg         <= e1z_reg * e2x_reg;
            p_xz_reg         <= e1x_reg * e2z_reg;
            p_xy_reg         <= e1x_reg * e2y_reg;
            p_yx_reg         <= e1y_reg * e2x_reg;
            dcx2_reg         <= dcx1_reg;
            dcz2_reg         <= dcz1_reg;
            ay2_reg          <= ay1_reg;
            side2_reg.cy     <= cy1_reg;
            side2_reg.rad    <= rad1_reg;
            side2_reg.reject <= reject;
            side2_reg.degen  <= 1'b0;
            side2_reg.neg    <= 1'b0;
        end
    end

    // ---- stage 3: plane normal
    logic v3_reg;
    logic signed [sth_pkg::NW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [sth_pkg::DW-1:0] dcx3_reg, dcz3_reg;
    logic signed [sth_pkg::CW-1:0] ay3_reg;
    sth_pkg::sth_side_t            side3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg    <= sth_pkg::NW'(p_yz_reg) - sth_pkg::NW'(p_zy_reg);
            ny_reg    <= sth_pkg::NW'(p_zx_reg) - sth_pkg::NW'(p_xz_reg);
            nz_reg    <= sth_pkg::NW'(p_xy_reg) - sth_pkg::NW'(p_yx_reg);
            dcx3_reg  <= dcx2_reg;
            dcz3_reg  <= dcz2_reg;
            ay3_reg   <= ay2_reg;
            side3_reg <= side2_reg;
        end
    end

    // ---- stage 4: split products n * d, |ny|, zero-normal flag
    logic v4_reg;
    logic signed [sth_pkg::LPW-1:0] ly_reg, lx_reg, lz_reg;
    logic signed [sth_pkg::HPW-1:0] hy_reg, hx_reg, hz_reg;
    logic [sth_pkg::NW-1:0]         nymag4_reg;
    logic                           nyneg4_reg;
    sth_pkg::sth_side_t             side4_reg;
    logic signed [sth_pkg::DW-1:0]  ay_d;

    assign ay_d = sth_pkg::DW'(ay3_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ly_reg          <= $signed({1'b0, ny_reg[sth_pkg::LW-1:0]}) * ay_d;
            lx_reg          <= $signed({1'b0, nx_reg[sth_pkg::LW-1:0]}) * dcx3_reg;
            lz_reg          <= $signed({1'b0, nz_reg[sth_pkg::LW-1:0]}) * dcz3_reg;
            hy_reg          <= $signed(ny_reg[sth_pkg::NW-1:sth_pkg::LW]) * ay_d;
            hx_reg          <= $signed(nx_reg[sth_pkg::NW-1:sth_pkg::LW]) * dcx3_reg;
            hz_reg          <= $signed(nz_reg[sth_pkg::NW-1:sth_pkg::LW]) * dcz3_reg;
            nymag4_reg      <= ny_reg[sth_pkg::NW-1] ? sth_pkg::NW'(-ny_reg)
                                                     : sth_pkg::NW'(ny_reg);
            nyneg4_reg      <= ny_reg[sth_pkg::NW-1];
            side4_reg       <= '{cy: side3_reg.cy, rad: side3_reg.rad,
                                 reject: side3_reg.reject, degen: (ny_reg == '0),
                                 neg: side3_reg.neg};
        end
    end

    // ---- stage 5: recombine slices
    logic v5_reg;
    logic signed [sth_pkg::TW-1:0] ty_reg, tx_reg, tz_reg;
    logic [sth_pkg::NW-1:0]        nymag5_reg;
    logic                          nyneg5_reg;
    sth_pkg::sth_side_t            side5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ty_reg     <= $signed({hy_reg, {sth_pkg::LW{1'b0}}}) + sth_pkg::TW'(ly_reg);
            tx_reg     <= $signed({hx_reg, {sth_pkg::LW{1'b0}}}) + sth_pkg::TW'(lx_reg);
            tz_reg     <= $signed({hz_reg, {sth_pkg::LW{1'b0}}}) + sth_pkg::TW'(lz_reg);
            nymag5_reg <= nymag4_reg;
            nyneg5_reg <= nyneg4_reg;
            side5_reg  <= side4_reg;
        end
    end

    // ---- stage 6: numerator
    logic v6_reg;
    logic signed [sth_pkg::NUMW-1:0] num_reg;
    logic [sth_pkg::NW-1:0]          nymag6_reg;
    logic                            nyneg6_reg;
    sth_pkg::sth_side_t              side6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= sth_pkg::NUMW'(ty_reg) - sth_pkg::NUMW'(tx_reg)
                        - sth_pkg::NUMW'(tz_reg);
            nymag6_reg <= nymag5_reg;
            nyneg6_reg <= nyneg5_reg;
            side6_reg  <= side5_reg;
        end
    end

    // ---- stage 7: magnitude and quotient sign
    logic v7_reg;
    logic [sth_pkg::MW-1:0] nummag_reg;
    logic [sth_pkg::NW-1:0] nymag7_reg;
    sth_pkg::sth_side_t     side7_reg;
    logic [sth_pkg::NUMW-1:0] num_abs;

    assign num_abs = num_reg[sth_pkg::NUMW-1] ? sth_pkg::NUMW'(-num_reg)
                                              : sth_pkg::NUMW'(num_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            nummag_reg    <= num_abs[sth_pkg::MW-1:0];
            nymag7_reg    <= nymag6_reg;
            side7_reg     <= '{cy: side6_reg.cy, rad: side6_reg.rad,
                               reject: side6_reg.reject, degen: side6_reg.degen,
                               neg: num_reg[sth_pkg::NUMW-1] ^ nyneg6_reg};
        end
    end

    // front valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // ---- divider
    logic                   dv_valid;
    logic [sth_pkg::MW-1:0] dv_quo;
    sth_pkg::sth_side_t     dv_side;

    sth_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_mag    (nummag_reg),
        .in_div    (nymag7_reg),
        .in_side   (side7_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // ---- back stage 1: signed quotient, height band
    logic vf_reg;
    logic signed [sth_pkg::NUMW-1:0] q_reg;
    logic signed [sth_pkg::BW-1:0]   lo_reg, hi_reg;
    sth_pkg::sth_side_t              sidef_reg;
    logic signed [sth_pkg::BW-1:0]   cy_b, rad_f;

    assign cy_b  = sth_pkg::BW'(dv_side.cy);
    assign rad_f = $signed({3'b000, dv_side.rad});

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg     <= dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
            lo_reg    <= cy_b - rad_f;
            hi_reg    <= cy_b + rad_f;
            sidef_reg <= dv_side;
        end
    end

    // ---- back stage 2: band test, saturation, output register
    logic signed [sth_pkg::NUMW-1:0] hmax_w, hmin_w;
    logic                            in_band, hit;
    logic signed [sth_pkg::CW-1:0]   height_sat;

    assign hmax_w  = sth_pkg::NUMW'({1'b0, {(sth_pkg::CW-1){1'b1}}});
    assign hmin_w  = -hmax_w - sth_pkg::NUMW'(1);
    assign in_band = (q_reg >= sth_pkg::NUMW'(lo_reg)) && (q_reg <= sth_pkg::NUMW'(hi_reg));
    assign hit     = !sidef_reg.reject && !sidef_reg.degen && in_band;

    always_comb begin
        if (q_reg > hmax_w) begin
            height_sat = hmax_w[sth_pkg::CW-1:0];
        end else if (q_reg < hmin_w) begin
            height_sat = hmin_w[sth_pkg::CW-1:0];
        end else begin
            height_sat = q_reg[sth_pkg::CW-1:0];
        end
    end

    logic                          m_valid_reg, m_hit_reg, m_degenerate_reg;
    logic signed [sth_pkg::CW-1:0] m_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vf_reg      <= dv_valid;
            m_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg        <= hit;
            m_height_reg     <= hit ? height_sat : '0;
            m_degenerate_reg <= !sidef_reg.reject && sidef_reg.degen;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_plane_height = m_height_reg;
    assign m_degenerate   = m_degenerate_reg;

    // ---- checks
    a_degen_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> !m_hit)
        else $error("degenerate result flagged as hit");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_plane_height == '0)
        else $error("nonzero height on a miss");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vf_reg) && $stable(v7_reg))
        else $error("pipeline moved during a stall");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for sphere_triangle_height_test
// Directed stimulus table followed by randomized triangle/sphere items over
// several radius settings, with random idling and backpressure on both
// channels. Every result is compared against its typed table value or a
// bit-accurate local height predictor.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CW = sth_pkg::CW;
    localparam int RW = sth_pkg::RW;
    localparam int FW = sth_pkg::FW;
    localparam logic [RW-1:0] RAD_RESET = sth_pkg::RAD_RESET;

    // extra wait at the end, run once every result has come back
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 400;

    typedef logic signed [255:0] wide_t;

    // one sphere/triangle query
    typedef struct packed {
        logic signed [CW-1:0] cx, cy, cz;
        logic signed [CW-1:0] ax, ay, az;
        logic signed [CW-1:0] bx, by, bz;
        logic signed [CW-1:0] gx, gy, gz;
    } query_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] height;
        logic                 degen;
    } height_res_t;

    // directed row: optional radius write before it, optional typed result
    typedef struct packed {
        logic        set_rad;
        logic [RW-1:0] rad;
        query_t      q;
        logic        typed;
        height_res_t res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [RW-1:0] cfg_sphere_radius = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    query_t query_drv = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic signed [CW-1:0] m_plane_height;
    logic m_degenerate;

    // bench copy of the radius register
    logic [RW-1:0] radius_shadow = RAD_RESET;

    height_res_t height_q[$];
    int unsigned n_items, n_results, n_hits, n_degen, n_mismatch, cycles;
    logic quiet = 1'b0;       // no idling on either side
    logic hold_req = 1'b0;    // ask the receiver for one long hold-off
    logic hold_seen = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sphere_triangle_height_test u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_sphere_radius(cfg_sphere_radius),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_center_x       (query_drv.cx),
        .s_center_y       (query_drv.cy),
        .s_center_z       (query_drv.cz),
        .s_vert_a_x       (query_drv.ax),
        .s_vert_a_y       (query_drv.ay),
        .s_vert_a_z       (query_drv.az),
        .s_vert_b_x       (query_drv.bx),
        .s_vert_b_y       (query_drv.by),
        .s_vert_b_z       (query_drv.bz),
        .s_vert_c_x       (query_drv.gx),
        .s_vert_c_y       (query_drv.gy),
        .s_vert_c_z       (query_drv.gz),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_plane_height   (m_plane_height),
        .m_degenerate     (m_degenerate)
    );

    // -----------------------------------------------------------------------
    // height predictor: exact wide integer math, truncating divide
    // -----------------------------------------------------------------------
    function automatic height_res_t predict_height(query_t q, logic [RW-1:0] rad);
        longint r, cx, cz, xlo, xhi, zlo, zhi;
        wide_t e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, num, quo, lo, hi;
        height_res_t res;
        r   = longint'(rad);
        cx  = q.cx;
        cz  = q.cz;
        xlo = q.ax; xhi = q.ax; zlo = q.az; zhi = q.az;
        if (q.bx < xlo) xlo = q.bx;
        if (q.gx < xlo) xlo = q.gx;
        if (q.bx > xhi) xhi = q.bx;
        if (q.gx > xhi) xhi = q.gx;
        if (q.bz < zlo) zlo = q.bz;
        if (q.gz < zlo) zlo = q.gz;
        if (q.bz > zhi) zhi = q.bz;
        if (q.gz > zhi) zhi = q.gz;
        res = '0;
        // box reject, edges count as inside
        if (cx < xlo - r || cx > xhi + r || cz < zlo - r || cz > zhi + r)
            return res;
        e1x = longint'(q.bx) - longint'(q.ax);
        e1y = longint'(q.by) - longint'(q.ay);
        e1z = longint'(q.bz) - longint'(q.az);
        e2x = longint'(q.gx) - longint'(q.ax);
        e2y = longint'(q.gy) - longint'(q.ay);
        e2z = longint'(q.gz) - longint'(q.az);
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        if (ny == 0) begin
            res.degen = 1'b1;
            return res;
        end
        e1x = longint'(q.cx) - longint'(q.ax);   // reuse as center offsets
        e1z = longint'(q.cz) - longint'(q.az);
        num = wide_t'(q.ay) * ny - nx * e1x - nz * e1z;
        quo = num / ny;                          // truncates toward zero
        lo  = longint'(q.cy) - r;
        hi  = longint'(q.cy) + r;
        if (quo >= lo && quo <= hi) begin
            res.hit = 1'b1;
            if (quo > wide_t'(longint'(2147483647)))
                res.height = {1'b0, {(CW-1){1'b1}}};
            else if (quo < wide_t'(-longint'(2147483647) - longint'(1)))
                res.height = {1'b1, {(CW-1){1'b0}}};
            else
                res.height = quo[CW-1:0];
        end
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // random query shapes
    // -----------------------------------------------------------------------
    function automatic logic signed [CW-1:0] jitter(logic signed [CW-1:0] base, int sh);
        longint span;
        span = longint'(1) << sh;
        return base + CW'(longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic query_t random_query();
        query_t q;
        int pick, sh, ysh;
        pick = $urandom_range(0, 99);
        sh   = $urandom_range(2, 20);
        ysh  = $urandom_range(2, 18);
        q.cx = CW'(longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29));
        q.cy = CW'(longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29));
        q.cz = CW'(longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29));
        q.ax = jitter(q.cx, sh); q.az = jitter(q.cz, sh); q.ay = jitter(q.cy, ysh);
        q.bx = jitter(q.cx, sh); q.bz = jitter(q.cz, sh); q.by = jitter(q.cy, ysh);
        q.gx = jitter(q.cx, sh); q.gz = jitter(q.cz, sh); q.gy = jitter(q.cy, ysh);
        if (pick < 60) begin
            // near-horizontal triangle around the center: mostly hits/near misses
        end else if (pick < 68) begin
            // vertical wall: all x equal, zero y normal
            q.bx = q.ax; q.gx = q.ax;
            q.cx = q.ax;
        end else if (pick < 74) begin
            // collapsed triangle, two vertices coincide
            q.gx = q.bx; q.gy = q.by; q.gz = q.bz;
        end else if (pick < 82) begin
            // center pushed well outside the box
            q.cx = q.cx + CW'(longint'(1) << 30);
        end else begin
            q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        return q;
    endfunction

    // -----------------------------------------------------------------------
    // sender side
    // -----------------------------------------------------------------------
    task automatic offer_query(query_t q, logic typed, height_res_t res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        query_drv <= q;
        do @(posedge aclk); while (!s_ready);
        height_q.insert(height_q.size(), typed ? res : predict_height(q, radius_shadow));
        n_items++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (height_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // radius writes only while the pipeline is empty
    task automatic write_radius(logic [RW-1:0] rad);
        wait_results_drained();
        cfg_valid         <= 1'b1;
        cfg_sphere_radius <= rad;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        radius_shadow = rad;
    endtask

    // -----------------------------------------------------------------------
    // receiver side: random stall bursts, one long hold-off on request
    // -----------------------------------------------------------------------
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_seen) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_seen = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        height_res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (height_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result transaction hit=%0b h=%0d deg=%0b",
                             m_hit, m_plane_height, m_degenerate);
            end else begin
                want = height_q.pop_front();
                if (m_hit !== want.hit || m_plane_height !== want.height ||
                    m_degenerate !== want.degen) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"ERROR: result %0d exp hit=%0b h=%0d deg=%0b",
                                  " got hit=%0b h=%0d deg=%0b"},
                                 n_results, want.hit, want.height, want.degen,
                                 m_hit, m_plane_height, m_degenerate);
                end
                if (want.hit) n_hits++;
                if (want.degen) n_degen++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, height_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    function automatic dir_row_t mk_row(logic set_rad, logic [RW-1:0] rad, query_t q,
                                        logic typed, logic hit, int height, logic degen);
        dir_row_t d;
        d.set_rad = set_rad;
        d.rad     = rad;
        d.q       = q;
        d.typed   = typed;
        d.res     = '{hit: hit, height: CW'(height), degen: degen};
        return d;
    endfunction

    initial begin
        dir_row_t dir_tab[$];
        query_t flat, q;
        logic [RW-1:0] phase_rad[6];
        localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
        localparam logic signed [CW-1:0] SMAX = 32'sh7fff_ffff;
        localparam logic signed [CW-1:0] SMIN = 32'sh8000_0000;

        // flat triangle at y = 1.0 spanning the origin corner
        flat = '{cx: 0, cy: ONE, cz: 0, ax: 0, ay: ONE, az: 0,
                 bx: ONE, by: ONE, bz: 0, gx: 0, gy: ONE, gz: ONE};

        // at reset radius 0.5
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, '0, 1, 0, 0, 1));     // collapsed at origin
        q = '0; q.cx = SMAX;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 0));      // far outside the box
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, flat, 1, 1, ONE, 0)); // center on the plane
        q = flat; q.cy = 10 * ONE;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 0));      // well above: no hit
        q = flat; q.cy = ONE + 32'sh8000;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 1, ONE, 0));    // band edge counts
        q = flat; q.cx = ONE + 32'sh8000; q.cz = -32'sh8000;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 1, ONE, 0));    // box corner counts
        q = flat; q.cx = ONE + 32'sh8001;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 0));      // just past box edge
        q = '{cx: 0, cy: 0, cz: 0, ax: 0, ay: 0, az: 0,
              bx: ONE, by: 0, bz: 0, gx: 0, gy: ONE, gz: 0};
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 1));      // vertical wall
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, '1, 0, 0, 0, 0));     // all fields -1
        q = {12{SMAX}};
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 1));      // all max: collapsed
        q = {12{SMIN}};
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 1));      // all min: collapsed
        q = '{cx: 0, cy: 0, cz: 0, ax: SMIN, ay: SMAX, az: SMIN,
              bx: SMAX, by: SMIN, bz: SMIN, gx: SMIN, gy: SMIN, gz: SMAX};
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 0, 0, 0, 0));      // huge steep plane
        // largest radius: saturation both ways
        q = '{cx: 2, cy: SMAX, cz: 0, ax: 0, ay: 0, az: 0,
              bx: 1, by: SMAX, bz: 0, gx: 0, gy: 0, gz: 1};
        dir_tab.insert(dir_tab.size(), mk_row(1, {RW{1'b1}}, q, 0, 0, 0, 0));
        q.cx = -2; q.cy = SMIN;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 0, 0, 0, 0));
        q.cx = -1; q.cy = SMAX; q.by = SMIN;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 0, 0, 0, 0));
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 0, 0, 0, 0));
        // zero radius: exact plane touch and off-by-one
        dir_tab.insert(dir_tab.size(), mk_row(1, 0, flat, 1, 1, ONE, 0));
        q = flat; q.cy = ONE + 1;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 0));
        q = flat; q.cx = -1;
        dir_tab.insert(dir_tab.size(), mk_row(0, 0, q, 1, 0, 0, 0));

        phase_rad[0] = RAD_RESET;
        phase_rad[1] = {RW{1'b1}};
        phase_rad[2] = RW'(1) << FW;
        phase_rad[3] = RW'($urandom_range(0, 1 << 12));
        phase_rad[4] = RW'($urandom);
        phase_rad[5] = RW'($urandom_range(0, 1 << 22));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].set_rad) write_radius(dir_tab[i].rad);
            offer_query(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].res);
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_radius(phase_rad[ph]);
            if (ph == 1) hold_req = 1'b1;   // fills the pipeline, stalls s_ready
            if (ph == 5) quiet = 1'b1;      // closing stretch at full rate
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                offer_query(random_query(), 1'b0, '0);
                // mid-phase pause until every pending result has come back
                if (ph == 3 && k == PHASE_ITEMS / 2) wait_results_drained();
            end
        end
        s_valid <= 1'b0;

        while (height_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d queries over several radius settings: %0d hits, %0d zero-normal planes",
                 n_items, n_hits, n_degen);
        $display("results checked %0d, mismatches %0d, long hold-off seen %0b",
                 n_results, n_mismatch, hold_seen);
        if (n_mismatch == 0 && height_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
